[rtl/core/qsr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qsr_pkg: shared types and constants for the smallest-three restore
// Component format, derived arithmetic widths and the sideband record that
// travels alongside the arithmetic through the pipeline.
// ----------------------------------------------------------------------------
package qsr_pkg;

  // Component width, signed Q1.(CompWidth-1)
  localparam int unsigned CompWidth = 16;

  // Square of a component is at most 2^(2W-2): 2W-1 bits unsigned
  localparam int unsigned SqWidth   = 2 * CompWidth - 1;
  // Sum of three squares stays below 2^(2W)
  localparam int unsigned SumWidth  = 2 * CompWidth;
  // Remainder (one - sum) is at most one, i.e. 2^(2W-2)
  localparam int unsigned RadWidth  = 2 * CompWidth - 1;

  // Square root unit: two result bits per stage
  localparam int unsigned ItersPerStage = 2;
  localparam int unsigned SqrtStages    = (CompWidth + ItersPerStage - 1) / ItersPerStage;
  localparam int unsigned SqrtIters     = SqrtStages * ItersPerStage;
  localparam int unsigned PadWidth      = 2 * SqrtIters;
  localparam int unsigned RemWidth      = CompWidth + 3;
  localparam int unsigned RootWidth     = CompWidth;

  // 1.0 in Q2.(2W-2)
  localparam logic [SumWidth-1:0] OneSq = {2'b01, {(2 * CompWidth - 2){1'b0}}};
  // Largest positive component, used when the root comes out as exactly 1.0
  localparam logic [RootWidth-1:0] MaxPos = {1'b0, {(RootWidth - 1){1'b1}}};

  typedef logic signed [CompWidth-1:0] comp_t;

  // Where the restored component is placed
  typedef enum logic [1:0] {
    SlotX = 2'd0,
    SlotY = 2'd1,
    SlotZ = 2'd2,
    SlotW = 2'd3
  } slot_e;

  // Carried unchanged alongside the root computation
  typedef struct packed {
    comp_t a;
    comp_t b;
    comp_t c;
    slot_e slot;
  } side_t;

endpackage
`default_nettype wire

[rtl/core/qsr_sqsum.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qsr_sqsum: squares and remainder
// Stage 1 squares the three components, stage 2 sums them and forms
// one minus the sum, forced to zero when the sum reaches one.
// ----------------------------------------------------------------------------
module qsr_sqsum (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  qsr_pkg::side_t                side_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [qsr_pkg::RadWidth-1:0]  rad_o,
  output qsr_pkg::side_t                side_o
);

  logic signed [2*qsr_pkg::CompWidth-1:0] prod_a, prod_b, prod_c;
  logic [qsr_pkg::SqWidth-1:0]  sq_a_q, sq_b_q, sq_c_q;
  logic [qsr_pkg::SumWidth-1:0] sum;
  logic [qsr_pkg::SumWidth-1:0] diff;
  logic [qsr_pkg::RadWidth-1:0] rad_d, rad_q;
  qsr_pkg::side_t               side1_q, side2_q;
  logic                         v1_q, v2_q;
  logic                         adv1, adv2;

  // Stage advances when empty or when its contents move on
  assign adv2    = !v2_q || !stall_i;
  assign adv1    = !v1_q || adv2;
  assign stall_o = !adv1;

  assign prod_a = side_i.a * side_i.a;
  assign prod_b = side_i.b * side_i.b;
  assign prod_c = side_i.c * side_i.c;

  assign sum  = qsr_pkg::SumWidth'(sq_a_q) + qsr_pkg::SumWidth'(sq_b_q)
              + qsr_pkg::SumWidth'(sq_c_q);
  assign diff = qsr_pkg::OneSq - sum;

  always_comb begin
    if (sum < qsr_pkg::OneSq) begin
      rad_d = diff[qsr_pkg::RadWidth-1:0];
    end else begin
      rad_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && valid_i) begin
      sq_a_q  <= prod_a[qsr_pkg::SqWidth-1:0];
      sq_b_q  <= prod_b[qsr_pkg::SqWidth-1:0];
      sq_c_q  <= prod_c[qsr_pkg::SqWidth-1:0];
      side1_q <= side_i;
    end
    if (adv2 && v1_q) begin
      rad_q   <= rad_d;
      side2_q <= side1_q;
    end
  end

  assign valid_o = v2_q;
  assign rad_o   = rad_q;
  assign side_o  = side2_q;

endmodule
`default_nettype wire

[rtl/core/qsr_isqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qsr_isqrt: pipelined integer square root
// Digit-by-digit restoring root, two result bits per stage; truncates and
// saturates a root of exactly 1.0 to the largest positive component.
// ----------------------------------------------------------------------------
module qsr_isqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           stall_o,
  input  logic [qsr_pkg::RadWidth-1:0]   rad_i,
  input  qsr_pkg::side_t                 side_i,
  output logic                           valid_o,
  input  logic                           stall_i,
  output logic [qsr_pkg::RootWidth-1:0]  root_o,
  output qsr_pkg::side_t                 side_o
);

  localparam int unsigned Stages   = qsr_pkg::SqrtStages;
  localparam int unsigned CmpWidth = qsr_pkg::RemWidth + qsr_pkg::SqrtIters;

  typedef struct packed {
    logic [qsr_pkg::PadWidth-1:0]  rad;
    logic [qsr_pkg::RemWidth-1:0]  rem;
    logic [qsr_pkg::SqrtIters-1:0] root;
  } sq_state_t;

  function automatic sq_state_t sqrt_step(sq_state_t s);
    sq_state_t                    r;
    logic [qsr_pkg::RemWidth-1:0] trial;
    r = s;
    for (int j = 0; j < qsr_pkg::ItersPerStage; j++) begin
      r.rem = {r.rem[qsr_pkg::RemWidth-3:0], r.rad[qsr_pkg::PadWidth-1 -: 2]};
      r.rad = {r.rad[qsr_pkg::PadWidth-3:0], 2'b00};
      trial = (qsr_pkg::RemWidth'(r.root) << 2) | qsr_pkg::RemWidth'(1);
      if (r.rem >= trial) begin
        r.rem  = r.rem - trial;
        r.root = {r.root[qsr_pkg::SqrtIters-2:0], 1'b1};
      end else begin
        r.root = {r.root[qsr_pkg::SqrtIters-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  logic [Stages-1:0] v_q;
  logic [Stages-1:0] v_in;
  logic [Stages-1:0] adv;
  sq_state_t         st_q   [Stages];
  sq_state_t         st_in  [Stages];
  sq_state_t         st_nxt [Stages];
  qsr_pkg::side_t    side_q [Stages];
  qsr_pkg::side_t    side_in[Stages];

  logic [qsr_pkg::SqrtIters-1:0] fin_root;
  logic [qsr_pkg::RemWidth-1:0]  fin_rem;

  // Ready chain from the output back to the input
  always_comb begin
    adv[Stages-1] = !v_q[Stages-1] || !stall_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign stall_o = !adv[0];

  always_comb begin
    for (int k = 0; k < Stages; k++) begin
      if (k == 0) begin
        v_in[k]       = valid_i;
        st_in[k].rad  = qsr_pkg::PadWidth'(rad_i);
        st_in[k].rem  = '0;
        st_in[k].root = '0;
        side_in[k]    = side_i;
      end else begin
        v_in[k]    = v_q[k-1];
        st_in[k]   = st_q[k-1];
        side_in[k] = side_q[k-1];
      end
      st_nxt[k] = sqrt_step(st_in[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < Stages; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Stages; k++) begin
      if (adv[k] && v_in[k]) begin
        st_q[k]   <= st_nxt[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign fin_root = st_q[Stages-1].root;
  assign fin_rem  = st_q[Stages-1].rem;

  // Root is at most 1.0; a root of 1.0 saturates
  assign root_o  = (|fin_root[qsr_pkg::SqrtIters-1:qsr_pkg::RootWidth-1])
                 ? qsr_pkg::MaxPos : fin_root[qsr_pkg::RootWidth-1:0];
  assign valid_o = v_q[Stages-1];
  assign side_o  = side_q[Stages-1];

  // Root never exceeds 1.0
  a_root_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[Stages-1] |-> (fin_root <= (qsr_pkg::SqrtIters'(1) << (qsr_pkg::CompWidth - 1))))
    else $error("square root above one");

  // Floor root leaves a remainder of at most twice the root
  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[Stages-1] |-> (CmpWidth'(fin_rem) <= CmpWidth'({fin_root, 1'b0})))
    else $error("square root remainder out of bound");

  // A held first stage keeps its transaction
  a_hold_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[0] && !adv[0]) |=> (v_q[0] && $stable(st_q[0]) && $stable(side_q[0])))
    else $error("first root stage lost a held transaction");

endmodule
`default_nettype wire

[rtl/core/qsr_place.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qsr_place: component placement and output register
// Puts the restored component into the slot named by the index.
// ----------------------------------------------------------------------------
module qsr_place (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           stall_o,
  input  logic [qsr_pkg::RootWidth-1:0]  root_i,
  input  qsr_pkg::side_t                 side_i,
  output logic                           valid_o,
  input  logic                           stall_i,
  output qsr_pkg::comp_t                 quat_x_o,
  output qsr_pkg::comp_t                 quat_y_o,
  output qsr_pkg::comp_t                 quat_z_o,
  output qsr_pkg::comp_t                 quat_w_o
);

  qsr_pkg::comp_t r;
  qsr_pkg::comp_t x_d, y_d, z_d, w_d;
  qsr_pkg::comp_t x_q, y_q, z_q, w_q;
  logic           v_q;
  logic           adv;

  assign adv     = !v_q || !stall_i;
  assign stall_o = !adv;
  assign r       = qsr_pkg::comp_t'(root_i);

  always_comb begin
    unique case (side_i.slot)
      qsr_pkg::SlotX: begin
        x_d = r;        y_d = side_i.b; z_d = side_i.c; w_d = side_i.a;
      end
      qsr_pkg::SlotY: begin
        x_d = side_i.b; y_d = r;        z_d = side_i.c; w_d = side_i.a;
      end
      qsr_pkg::SlotZ: begin
        x_d = side_i.b; y_d = side_i.c; z_d = r;        w_d = side_i.a;
      end
      qsr_pkg::SlotW: begin
        x_d = side_i.b; y_d = side_i.c; z_d = side_i.a; w_d = r;
      end
      default: begin
        x_d = side_i.b; y_d = side_i.c; z_d = side_i.a; w_d = r;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
      w_q <= w_d;
    end
  end

  assign valid_o  = v_q;
  assign quat_x_o = x_q;
  assign quat_y_o = y_q;
  assign quat_z_o = z_q;
  assign quat_w_o = w_q;

endmodule
`default_nettype wire

[rtl/core/quaternion_smallest_three_restore.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_smallest_three_restore: smallest-three quaternion decoder
// Rebuilds a unit quaternion from three stored Q1.15 components and a
// 2-bit placement index.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the output side does not stall and
// returns one result transaction for each, in order: one stage of three
// 16x16 multipliers squares the stored components, one stage sums the
// squares and forms 1 - sum (zero once the sum reaches one), eight stages
// of a restoring square root produce two root bits each, and a final stage
// places the restored component and registers the result.
// Every stage holds its own valid bit, so a stall at the output only fills
// empty stages behind it and in_stall_o rises only once the pipe is full.
// Formats: inputs and outputs signed Q1.15, squares Q2.30, root truncated
// to Q0.15; a root of exactly 1.0 (all stored components zero) becomes 32767.
// ----------------------------------------------------------------------------
module quaternion_smallest_three_restore (
  input  logic           clk_i,
  input  logic           rst_ni,
  // input channel
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  qsr_pkg::comp_t comp_a_i,
  input  qsr_pkg::comp_t comp_b_i,
  input  qsr_pkg::comp_t comp_c_i,
  input  logic [1:0]     missing_slot_i,
  // output channel
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output qsr_pkg::comp_t quat_x_o,
  output qsr_pkg::comp_t quat_y_o,
  output qsr_pkg::comp_t quat_z_o,
  output qsr_pkg::comp_t quat_w_o
);

  qsr_pkg::side_t               side_in;
  qsr_pkg::side_t               side_sum;
  qsr_pkg::side_t               side_root;
  logic [qsr_pkg::RadWidth-1:0] rad;
  logic [qsr_pkg::RootWidth-1:0] root;
  logic                         sum_valid, sum_stall;
  logic                         root_valid, root_stall;

  // The stored components and index ride along untouched until placement
  assign side_in.a    = comp_a_i;
  assign side_in.b    = comp_b_i;
  assign side_in.c    = comp_c_i;
  assign side_in.slot = qsr_pkg::slot_e'(missing_slot_i);

  // Squares and 1 - sum of squares
  qsr_sqsum u_sqsum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .side_i  (side_in),
    .valid_o (sum_valid),
    .stall_i (sum_stall),
    .rad_o   (rad),
    .side_o  (side_sum)
  );

  // Pipelined square root, saturated to the largest positive component
  qsr_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_valid),
    .stall_o (sum_stall),
    .rad_i   (rad),
    .side_i  (side_sum),
    .valid_o (root_valid),
    .stall_i (root_stall),
    .root_o  (root),
    .side_o  (side_root)
  );

  // Placement by index and output register
  qsr_place u_place (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (root_valid),
    .stall_o  (root_stall),
    .root_i   (root),
    .side_i   (side_root),
    .valid_o  (out_valid_o),
    .stall_i  (out_stall_i),
    .quat_x_o (quat_x_o),
    .quat_y_o (quat_y_o),
    .quat_z_o (quat_z_o),
    .quat_w_o (quat_w_o)
  );

endmodule
`default_nettype wire

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for quaternion_smallest_three_restore
// Drives a short table of hand-picked transactions and then about 950
// random ones through the decoder. The sender works in bursts and the
// receiver stalls in changing patterns. Every result is compared, field by
// field, with the answer written in its table row or, for the other rows,
// with a quaternion rebuilt in the bench from the same stored components.
// ----------------------------------------------------------------------------
module tb_top;

  // Rebuilt quaternion, one field per output port
  typedef struct packed {
    qsr_pkg::comp_t x;
    qsr_pkg::comp_t y;
    qsr_pkg::comp_t z;
    qsr_pkg::comp_t w;
  } quat_t;

  // One line of stimulus; typed_exp marks rows whose answer is written in
  typedef struct packed {
    qsr_pkg::comp_t a;
    qsr_pkg::comp_t b;
    qsr_pkg::comp_t c;
    qsr_pkg::slot_e slot;
    logic           typed_exp;
    quat_t          want;
  } stim_row_t;

  localparam int RandomItems = 950;
  // Drain time after the pipe empties; leave a comfortable margin
  localparam int DrainCycles = 32;
  // Watchdog limit, in simulation time
  localparam int LimitTime   = 2_000_000;

  logic           clk_i;
  logic           rst_ni     = 1'b0;
  logic           in_valid   = 1'b0;
  logic           in_stall_o;
  qsr_pkg::comp_t comp_a     = '0;
  qsr_pkg::comp_t comp_b     = '0;
  qsr_pkg::comp_t comp_c     = '0;
  qsr_pkg::slot_e slot_drv   = qsr_pkg::SlotX;
  logic           out_valid_o;
  logic           out_stall  = 1'b0;
  qsr_pkg::comp_t quat_x_o;
  qsr_pkg::comp_t quat_y_o;
  qsr_pkg::comp_t quat_z_o;
  qsr_pkg::comp_t quat_w_o;

  // Travels with the payload so the monitor knows which answer to queue
  logic  row_typed  = 1'b0;
  quat_t row_want   = '0;

  stim_row_t directed_rows[$];
  quat_t     pending_quats[$];
  quat_t     oldest;

  int fails          = 0;
  int items_accepted = 0;
  int results_seen   = 0;
  int slot_count[4]  = '{0, 0, 0, 0};

  // Receiver stall pattern state
  int stall_mode       = 0;
  int stall_phase_left = 0;

  quaternion_smallest_three_restore dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .comp_a_i       (comp_a),
    .comp_b_i       (comp_b),
    .comp_c_i       (comp_c),
    .missing_slot_i (slot_drv),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .quat_x_o       (quat_x_o),
    .quat_y_o       (quat_y_o),
    .quat_z_o       (quat_z_o),
    .quat_w_o       (quat_w_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Largest r with r*r <= v, found one bit at a time from the top.
  // v is at most 2^(2W-2), so r needs W bits.
  function automatic logic [qsr_pkg::CompWidth-1:0] floor_sqrt(
      input logic [2*qsr_pkg::CompWidth-1:0] v);
    logic [qsr_pkg::CompWidth-1:0] root;
    logic [qsr_pkg::CompWidth-1:0] trial;
    root = '0;
    for (int i = qsr_pkg::CompWidth - 1; i >= 0; i--) begin
      trial = root | (qsr_pkg::CompWidth'(1) << i);
      if (64'(trial) * 64'(trial) <= 64'(v)) root = trial;
    end
    return root;
  endfunction

  function automatic quat_t restore_quat(input qsr_pkg::comp_t a, input qsr_pkg::comp_t b,
                                         input qsr_pkg::comp_t c,
                                         input qsr_pkg::slot_e slot);
    longint                        sa;
    longint                        sb;
    longint                        sc;
    longint                        sum_sq;
    longint                        unity;
    logic [qsr_pkg::CompWidth-1:0] root;
    qsr_pkg::comp_t                r;
    quat_t                         q;
    sa     = a;
    sb     = b;
    sc     = c;
    sum_sq = sa * sa + sb * sb + sc * sc;
    unity  = longint'(1) << (2 * qsr_pkg::CompWidth - 2);
    // Sum at or past one: nothing left for the missing component
    root   = '0;
    if (sum_sq < unity) root = floor_sqrt((2 * qsr_pkg::CompWidth)'(unity - sum_sq));
    // Exactly 1.0 cannot be held in Q1.15, clip to the largest positive value
    if (root > qsr_pkg::MaxPos) root = qsr_pkg::MaxPos;
    r = root;
    case (slot)
      qsr_pkg::SlotX: q = '{x: r, y: b, z: c, w: a};
      qsr_pkg::SlotY: q = '{x: b, y: r, z: c, w: a};
      qsr_pkg::SlotZ: q = '{x: b, y: c, z: r, w: a};
      default:        q = '{x: b, y: c, z: a, w: r};
    endcase
    return q;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  task automatic add_row(input int a, input int b, input int c,
                         input qsr_pkg::slot_e slot,
                         input logic typed_exp, input int x, input int y, input int z,
                         input int w);
    stim_row_t row;
    row.a         = qsr_pkg::comp_t'(a);
    row.b         = qsr_pkg::comp_t'(b);
    row.c         = qsr_pkg::comp_t'(c);
    row.slot      = slot;
    row.typed_exp = typed_exp;
    row.want      = '{x: qsr_pkg::comp_t'(x), y: qsr_pkg::comp_t'(y),
                      z: qsr_pkg::comp_t'(z), w: qsr_pkg::comp_t'(w)};
    directed_rows.push_back(row);
  endtask

  function automatic qsr_pkg::comp_t pick_special();
    case ($urandom_range(0, 6))
      0:       return qsr_pkg::comp_t'(0);
      1:       return qsr_pkg::comp_t'(1);
      2:       return qsr_pkg::comp_t'(-1);
      3:       return qsr_pkg::comp_t'(32767);
      4:       return qsr_pkg::comp_t'(-32768);
      5:       return qsr_pkg::comp_t'(16384);
      default: return qsr_pkg::comp_t'(-16384);
    endcase
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t row;
    int        kind;
    int        cv;
    longint    rem;
    row      = '0;
    row.slot = qsr_pkg::slot_e'($urandom_range(0, 3));
    kind     = $urandom_range(0, 99);
    if (kind < 40) begin
      // Proper stored triple: |each| <= 18918 keeps the sum of squares below one
      row.a = qsr_pkg::comp_t'(int'($urandom_range(0, 37836)) - 18918);
      row.b = qsr_pkg::comp_t'(int'($urandom_range(0, 37836)) - 18918);
      row.c = qsr_pkg::comp_t'(int'($urandom_range(0, 37836)) - 18918);
    end else if (kind < 60) begin
      // Third component picked so the sum of squares lands on or near one
      row.a = qsr_pkg::comp_t'($urandom);
      row.b = qsr_pkg::comp_t'(int'($urandom_range(0, 32768)) - 16384);
      rem   = (longint'(1) << 30) - longint'(row.a) * row.a - longint'(row.b) * row.b;
      if (rem > 0) begin
        cv = int'(floor_sqrt(32'(rem))) + int'($urandom_range(0, 4)) - 2;
        if (cv > 32767) cv = 32767;
        if ($urandom_range(0, 1) == 1) cv = -cv;
        row.c = qsr_pkg::comp_t'(cv);
      end else begin
        row.c = qsr_pkg::comp_t'($urandom);
      end
    end else if (kind < 80) begin
      row.a = qsr_pkg::comp_t'($urandom);
      row.b = qsr_pkg::comp_t'($urandom);
      row.c = qsr_pkg::comp_t'($urandom);
    end else if (kind < 90) begin
      // Tiny components: root close to the clipping point
      row.a = qsr_pkg::comp_t'(int'($urandom_range(0, 128)) - 64);
      row.b = qsr_pkg::comp_t'(int'($urandom_range(0, 128)) - 64);
      row.c = qsr_pkg::comp_t'(int'($urandom_range(0, 128)) - 64);
    end else begin
      row.a = pick_special();
      row.b = pick_special();
      row.c = pick_special();
    end
    return row;
  endfunction

  // Present one transaction and hold it until the decoder takes it
  task automatic send_row(input stim_row_t row);
    in_valid  <= 1'b1;
    comp_a    <= row.a;
    comp_b    <= row.b;
    comp_c    <= row.c;
    slot_drv  <= row.slot;
    row_typed <= row.typed_exp;
    row_want  <= row.want;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stalls in phases of random length, each phase with its own
  // character (free running, light, heavy, long runs)
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (stall_phase_left == 0) begin
      stall_mode       <= $urandom_range(0, 3);
      stall_phase_left <= $urandom_range(16, 96);
    end else begin
      stall_phase_left <= stall_phase_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= ($urandom_range(0, 15) == 0) ? ~out_stall : out_stall;
    endcase
  end

  // --------------------------------------------------------------------------
  // Monitor and scoreboard. Both channels are sampled at the clock edge, so
  // values seen here are those that stood before the edge.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input qsr_pkg::comp_t want,
                             input qsr_pkg::comp_t got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_valid && !in_stall_o) begin
      if (row_typed) pending_quats.push_back(row_want);
      else pending_quats.push_back(restore_quat(comp_a, comp_b, comp_c, slot_drv));
      items_accepted++;
      slot_count[slot_drv]++;
    end
    if (rst_ni && out_valid_o && !out_stall) begin
      results_seen++;
      if (pending_quats.size() == 0) begin
        $error("result transaction with nothing outstanding");
        fails++;
      end else begin
        oldest = pending_quats.pop_front();
        check_field("quat_x", oldest.x, quat_x_o);
        check_field("quat_y", oldest.y, quat_y_o);
        check_field("quat_z", oldest.z, quat_z_o);
        check_field("quat_w", oldest.w, quat_w_o);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int total;
    int idx;
    int burst;
    int gap;
    // All-zero triple: root is 1.0 and clips to 32767, once per placement
    add_row(0, 0, 0, qsr_pkg::SlotX, 1'b1, 32767, 0, 0, 0);
    add_row(0, 0, 0, qsr_pkg::SlotY, 1'b1, 0, 32767, 0, 0);
    add_row(0, 0, 0, qsr_pkg::SlotZ, 1'b1, 0, 0, 32767, 0);
    add_row(0, 0, 0, qsr_pkg::SlotW, 1'b1, 0, 0, 0, 32767);
    // Most negative value squares to exactly one: restored part is zero
    add_row(-32768, 0, 0, qsr_pkg::SlotW, 1'b1, 0, 0, -32768, 0);
    add_row(0, -32768, 0, qsr_pkg::SlotX, 1'b1, 0, -32768, 0, 0);
    add_row(0, 0, -32768, qsr_pkg::SlotY, 1'b1, 0, 0, -32768, 0);
    add_row(-32768, -32768, -32768, qsr_pkg::SlotZ, 1'b1, -32768, -32768, 0, -32768);
    // Sum far past one: restored part is zero
    add_row(32767, 32767, 32767, qsr_pkg::SlotW, 1'b1, 32767, 32767, 32767, 0);
    // Remaining rows go through the predictor
    add_row(32767, 0, 0, qsr_pkg::SlotX, 1'b0, 0, 0, 0, 0);
    add_row(16384, 16384, 16384, qsr_pkg::SlotY, 1'b0, 0, 0, 0, 0);
    add_row(-16384, 16384, -16384, qsr_pkg::SlotZ, 1'b0, 0, 0, 0, 0);
    add_row(0, 16384, -16384, qsr_pkg::SlotW, 1'b0, 0, 0, 0, 0);
    add_row(-1, -1, -1, qsr_pkg::SlotW, 1'b0, 0, 0, 0, 0);
    add_row(1, 0, 0, qsr_pkg::SlotX, 1'b0, 0, 0, 0, 0);
    add_row(23170, 0, 0, qsr_pkg::SlotY, 1'b0, 0, 0, 0, 0);
    add_row(-23170, 23170, 0, qsr_pkg::SlotZ, 1'b0, 0, 0, 0, 0);
    add_row(21845, -21846, 0, qsr_pkg::SlotW, 1'b0, 0, 0, 0, 0);
    add_row(-21846, 21845, -21846, qsr_pkg::SlotX, 1'b0, 0, 0, 0, 0);
    add_row(18918, -18918, 18918, qsr_pkg::SlotY, 1'b0, 0, 0, 0, 0);
    add_row(255, -256, 127, qsr_pkg::SlotZ, 1'b0, 0, 0, 0, 0);

    total = directed_rows.size() + RandomItems;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender: bursts of random length, a quarter of them run straight on
    idx = 0;
    while (idx < total) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && idx < total; k++) begin
        if (idx < directed_rows.size()) send_row(directed_rows[idx]);
        else send_row(random_row());
        idx++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid <= 1'b0;

    // Let the pipe empty, then watch a little longer for stray results
    while (pending_quats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d transactions (%0d from the table), %0d results compared.",
             items_accepted, directed_rows.size(), results_seen);
    $display("Placement mix x/y/z/w: %0d/%0d/%0d/%0d, receiver stalls in four patterns.",
             slot_count[0], slot_count[1], slot_count[2], slot_count[3]);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LimitTime);
    $display("watchdog expired, %0d results still outstanding", pending_quats.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
